[hw/rtl/bia_pkg.sv]
// Shared types, codes and widths for the bitmap ID allocator.
// No dependencies; imported by bitmap_id_allocator.
package bia_pkg;

   // Field widths fixed by the item format
   localparam int ID_W    = 10;
   localparam int COUNT_W = 11;
   localparam int WORD_W  = 32;
   localparam int BIT_W   = 5;
   localparam int MAX_IDS = 1024;

   typedef logic [1:0]         req_code_type;
   typedef logic [1:0]         status_type;
   typedef logic [ID_W-1:0]    id_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [WORD_W-1:0]  word_type;

   // Request codes; code 3 behaves as a query
   localparam req_code_type REQ_ALLOC = 2'd0;
   localparam req_code_type REQ_FREE  = 2'd1;
   localparam req_code_type REQ_QUERY = 2'd2;

   // Status codes
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_FULL     = 2'd1;
   localparam status_type ST_NOT_USED = 2'd2;

   // Position of the lowest clear bit of a word (0 when none is clear)
   function automatic logic [BIT_W-1:0] first_zero(input word_type w);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

[hw/rtl/bitmap_id_allocator.sv]
// Bitmap ID allocator: used-bit memory of 32-bit rows with a per-row full summary.
// Depends on bia_pkg.
//
// Each item is taken in S_IDLE and finished in S_EXEC: the accept edge reads one 32-bit row
// of the used-bit memory, and the edge that leaves S_EXEC, once the result register is free
// or being taken, applies the modify, writes the row back and loads the result register. No
// new item is taken until the last one has finished. An allocate picks the lowest row whose
// summary bit says it still has a free ID and then the lowest clear bit in that row, giving
// the lowest free ID. A row summary flag and a row-valid flag per row live in flip-flops;
// reset clears them at once, a row never written reads as all free, and no clearing pass is
// needed. IDs at or above the capacity (capped at 1024) are never in use. A finished result
// waits in the output register while the next item is accepted.
module bitmap_id_allocator #(
   parameter int NUM_IDS = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bia_pkg::req_code_type   req_type,
   input  bia_pkg::id_type         req_id,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output bia_pkg::id_type         rsp_result_id,
   output bia_pkg::status_type     rsp_status,
   output logic                    rsp_id_in_use,
   output bia_pkg::count_type      rsp_used_count
);
   import bia_pkg::*;

   localparam int IdSpace  = (NUM_IDS < MAX_IDS) ? NUM_IDS : MAX_IDS;
   localparam int Rows     = (IdSpace + WORD_W - 1) / WORD_W;
   localparam int RowAw    = (Rows > 1) ? $clog2(Rows) : 1;
   localparam int LastBits = IdSpace - (Rows - 1) * WORD_W;
   localparam word_type LastMask = (LastBits >= WORD_W) ? {WORD_W{1'b1}}
                                 : word_type'((64'd1 << LastBits) - 64'd1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   // Used-bit memory, one 32-bit row per entry
   word_type mem [Rows];

   logic               state_ff, state_in;
   logic [Rows-1:0]    full_ff, full_in;
   logic [Rows-1:0]    row_vld_ff, row_vld_in;
   count_type          count_ff, count_in;
   req_code_type       op_ff;
   id_type             id_ff;
   logic [RowAw-1:0]   row_ff;
   word_type           rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   id_type             rsp_id_ff;
   status_type         rsp_status_ff;
   logic               rsp_use_ff;
   count_type          rsp_count_ff;

   logic               accept;
   logic               finish;
   logic [RowAw-1:0]   alloc_row;
   logic [RowAw-1:0]   rd_row;
   logic               all_full;
   word_type           row_mask;
   word_type           word;
   word_type           word_eff;
   word_type           new_word;
   logic [BIT_W-1:0]   free_bit;
   logic               in_range;
   logic               was_used;
   logic               wr_en;
   id_type             res_id;
   status_type         res_status;
   logic               res_use;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign finish    = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // Pick the lowest row that still has a free ID
   always_comb begin
      alloc_row = '0;
      for (int r = Rows - 1; r >= 0; r--) begin
         if (!full_ff[r]) begin
            alloc_row = RowAw'(r);
         end
      end
   end

   assign all_full = &full_ff;
   assign rd_row   = (req_type == REQ_ALLOC) ? alloc_row : req_id[BIT_W +: RowAw];

   // Capture the item and read its row
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_type;
         id_ff  <= req_id;
         row_ff <= rd_row;
         rd_ff  <= mem[rd_row];
      end
   end

   // Modify the row
   always_comb begin
      row_mask = (row_ff == RowAw'(Rows - 1)) ? LastMask : {WORD_W{1'b1}};
      word     = row_vld_ff[row_ff] ? rd_ff : '0;
      word_eff = word | ~row_mask;
      free_bit = first_zero(word_eff);
      in_range = ({1'b0, id_ff} < COUNT_W'(IdSpace));
      was_used = in_range && word[id_ff[BIT_W-1:0]];
      new_word = word;
      wr_en    = 1'b0;
      res_id   = id_ff;
      res_status = ST_OK;
      res_use  = 1'b0;
      full_in    = full_ff;
      row_vld_in = row_vld_ff;
      count_in   = count_ff;
      unique case (op_ff)
         REQ_ALLOC: begin
            if (all_full) begin
               res_id     = '0;
               res_status = ST_FULL;
            end else begin
               new_word[free_bit] = 1'b1;
               wr_en    = 1'b1;
               res_id   = ID_W'({row_ff, free_bit});
               res_use  = 1'b1;
               full_in[row_ff] = &(new_word | ~row_mask);
               count_in = count_ff + COUNT_W'(1);
            end
         end
         REQ_FREE: begin
            if (was_used) begin
               new_word[id_ff[BIT_W-1:0]] = 1'b0;
               wr_en = 1'b1;
               full_in[row_ff] = 1'b0;
               if (count_ff != '0) begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end else begin
               res_status = ST_NOT_USED;
            end
         end
         default: begin
            res_use = was_used;
         end
      endcase
      if (wr_en) begin
         row_vld_in[row_ff] = 1'b1;
      end
   end

   // Write back the modified row
   always_ff @(posedge clock) begin
      if (finish && wr_en) begin
         mem[row_ff] <= new_word;
      end
   end

   // Advance the sequencer and the output valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         default: begin
            if (finish) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         full_ff      <= '0;
         row_vld_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            full_ff    <= full_in;
            row_vld_ff <= row_vld_in;
            count_ff   <= count_in;
         end
      end
   end

   // Hold the result item until taken
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_id_ff     <= res_id;
         rsp_status_ff <= res_status;
         rsp_use_ff    <= res_use;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_id  = rsp_id_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_id_in_use  = rsp_use_ff;
   assign rsp_used_count = rsp_count_ff;

   // Count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(IdSpace))
      else $error("used count above capacity");

   // Full status only when every ID is taken
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_used_count == COUNT_W'(IdSpace))
      else $error("full reported with free IDs left");

   // An allocate works on a row that still has room
   a_alloc_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC && op_ff == REQ_ALLOC && !all_full |-> !full_ff[row_ff])
      else $error("allocate picked a full row");

   // A successful allocate raises the count by one
   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      finish && op_ff == REQ_ALLOC && !all_full |=> count_ff == $past(count_ff) + 1'b1)
      else $error("allocate did not raise the count");

endmodule
